FILE: sv/assert_macros.svh
// Assertion macros used by the checker file of the project.
// Needs a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked on every rising edge, reset included
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

FILE: sv/hsl_pkg.sv
// Package for the HSL to RGB converter: widths, stage record types, part selection.
// No dependencies; used by every module of the converter.
`timescale 1ns / 1ps

package hsl_pkg;

    localparam int CHAN_W  = 8;            // one colour component
    localparam int SEXT_W  = 3;            // hue sextant 0..5
    localparam int RAMP_W  = 9;            // ramp 0..256
    localparam int CN_W    = 16;           // chroma numerator, at most 254*255
    localparam int XP_W    = CN_W + RAMP_W; // cn * ramp
    localparam int SUM_W   = XP_W + 1;     // part + m
    localparam int QX_W    = SUM_W - 8;    // sum / 256
    localparam int QE_W    = QX_W - 8;     // estimate of (sum / 256) / 255

    localparam int NUM_STAGES = 6;

    // Sextant codes of the hue wheel
    localparam logic [SEXT_W-1:0] SEXT_RY = 3'd0;
    localparam logic [SEXT_W-1:0] SEXT_YG = 3'd1;
    localparam logic [SEXT_W-1:0] SEXT_GC = 3'd2;
    localparam logic [SEXT_W-1:0] SEXT_CB = 3'd3;
    localparam logic [SEXT_W-1:0] SEXT_BM = 3'd4;

    typedef enum logic [1:0] {
        LANE_RED   = 2'd0,
        LANE_GREEN = 2'd1,
        LANE_BLUE  = 2'd2
    } t_lane;

    // Which term a channel adds to the lightness offset
    typedef enum logic [1:0] {
        PART_ZERO = 2'd0,
        PART_C    = 2'd1,
        PART_X    = 2'd2
    } t_part;

    // Result of the front stages, one per pixel
    typedef struct packed {
        logic              zero_sat;
        logic [SEXT_W-1:0] sext;
        logic [CN_W-1:0]   cn;
        logic [XP_W-1:0]   xp;
        logic [XP_W-1:0]   m;
    } t_front;

    // Per-sextant choice of term for each channel
    function automatic t_part part_sel(input logic [SEXT_W-1:0] sext, input t_lane lane);
        t_part p;
        p = PART_ZERO;
        case (sext)
            SEXT_RY: begin
                p = (lane == LANE_RED) ? PART_C : (lane == LANE_GREEN) ? PART_X : PART_ZERO;
            end
            SEXT_YG: begin
                p = (lane == LANE_RED) ? PART_X : (lane == LANE_GREEN) ? PART_C : PART_ZERO;
            end
            SEXT_GC: begin
                p = (lane == LANE_RED) ? PART_ZERO : (lane == LANE_GREEN) ? PART_C : PART_X;
            end
            SEXT_CB: begin
                p = (lane == LANE_RED) ? PART_ZERO : (lane == LANE_GREEN) ? PART_X : PART_C;
            end
            SEXT_BM: begin
                p = (lane == LANE_RED) ? PART_X : (lane == LANE_GREEN) ? PART_ZERO : PART_C;
            end
            default: begin
                p = (lane == LANE_RED) ? PART_C : (lane == LANE_GREEN) ? PART_ZERO : PART_X;
            end
        endcase
        return p;
    endfunction

endpackage

FILE: sv/hsl_front.sv
// Front stages 1..3: hue sextant and ramp, chroma numerator, X term and offset.
// Depends on hsl_pkg.
`timescale 1ns / 1ps

module hsl_front import hsl_pkg::*; (
    input  logic              i_clk,
    input  logic [2:0]        i_en,        // load enables of stages 1..3
    input  logic [CHAN_W-1:0] i_hue,
    input  logic [CHAN_W-1:0] i_sat,
    input  logic [CHAN_W-1:0] i_light,
    output t_front            o_front
);

    // Stage 1 registers
    logic [SEXT_W-1:0] r1_sext;
    logic [RAMP_W-1:0] r1_ramp;
    logic [CHAN_W-1:0] r1_d;
    logic [CHAN_W-1:0] r1_sat;
    logic [CHAN_W-1:0] r1_light;
    logic              r1_zero;
    // Stage 2 registers
    logic [SEXT_W-1:0] r2_sext;
    logic [RAMP_W-1:0] r2_ramp;
    logic [CN_W-1:0]   r2_cn;
    logic [CHAN_W-1:0] r2_light;
    logic              r2_zero;
    // Stage 3 register
    t_front            r3_front;

    logic [10:0]       w_hq;
    logic [9:0]        w_ramp;
    logic [8:0]        w_d;
    logic [XP_W-1:0]   w_lfull;
    logic [XP_W-1:0]   w_chalf;

    // hue * 6; ramp folds the low nine bits about 256
    assign w_hq   = {1'b0, i_hue, 2'b00} + {2'b00, i_hue, 1'b0};
    assign w_ramp = w_hq[8] ? (10'd512 - {1'b0, w_hq[8:0]}) : {1'b0, w_hq[8:0]};
    // 255 - |2l - 255|
    assign w_d    = i_light[7] ? (9'd510 - {i_light, 1'b0}) : {i_light, 1'b0};

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r1_sext  <= w_hq[10:8];
            r1_ramp  <= w_ramp[RAMP_W-1:0];
            r1_d     <= w_d[CHAN_W-1:0];
            r1_sat   <= i_sat;
            r1_light <= i_light;
            r1_zero  <= (i_sat == '0);
        end
    end

    // Chroma numerator
    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r2_sext  <= r1_sext;
            r2_ramp  <= r1_ramp;
            r2_cn    <= {8'd0, r1_d} * {8'd0, r1_sat};
            r2_light <= r1_light;
            r2_zero  <= r1_zero;
        end
    end

    // l*65280 = l*65536 - l*256; never below cn*128, so m stays non-negative
    assign w_lfull = {1'b0, r2_light, 16'd0} - {9'd0, r2_light, 8'd0};
    assign w_chalf = {2'b00, r2_cn, 7'd0};

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r3_front.zero_sat <= r2_zero;
            r3_front.sext     <= r2_sext;
            r3_front.cn       <= r2_cn;
            r3_front.xp       <= {9'd0, r2_cn} * {16'd0, r2_ramp};
            r3_front.m        <= w_lfull - w_chalf;
        end
    end

    assign o_front = r3_front;

endmodule

FILE: sv/hsl_chan.sv
// Channel stages 4..6: add term and offset, divide by 65280, clamp.
// Depends on hsl_pkg.
`timescale 1ns / 1ps

module hsl_chan import hsl_pkg::*; (
    input  logic              i_clk,
    input  logic [2:0]        i_en,        // load enables of stages 4..6
    input  t_part             i_part,
    input  t_front            i_front,
    output logic [CHAN_W-1:0] o_chan
);

    logic [QX_W-1:0]   r4_x;
    logic              r4_zero;
    logic [QX_W-1:0]   r5_x;
    logic [QE_W-1:0]   r5_qe;
    logic              r5_zero;
    logic [CHAN_W-1:0] r6_chan;

    logic [SUM_W-1:0]  w_part;
    logic [SUM_W-1:0]  w_sum;
    logic [QX_W+8:0]   w_x257;
    logic [QX_W+1:0]   w_qe255;
    logic [QX_W+1:0]   w_rem;
    logic [QE_W:0]     w_q;
    logic [CHAN_W-1:0] n_chan;

    // Term selection and sum
    always_comb begin
        case (i_part)
            PART_C:  w_part = {{(SUM_W-CN_W-8){1'b0}}, i_front.cn, 8'd0};
            PART_X:  w_part = {1'b0, i_front.xp};
            default: w_part = '0;
        endcase
    end
    assign w_sum = w_part + {1'b0, i_front.m};

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r4_x    <= w_sum[SUM_W-1:8];
            r4_zero <= i_front.zero_sat;
        end
    end

    // x*257/65536 is floor(x/255) or one below
    assign w_x257 = {1'b0, r4_x, 8'd0} + {9'd0, r4_x};

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r5_x    <= r4_x;
            r5_qe   <= w_x257[QX_W+7:16];
            r5_zero <= r4_zero;
        end
    end

    // Correct the estimate by one, clamp, and force white for zero saturation
    assign w_qe255 = {2'b00, r5_qe, 8'd0} - {10'd0, r5_qe};
    assign w_rem   = {2'b00, r5_x} - w_qe255;
    assign w_q     = {1'b0, r5_qe} + ((w_rem >= (QX_W+2)'(255)) ? (QE_W+1)'(1) : '0);

    always_comb begin
        if (r5_zero || (w_q > (QE_W+1)'(255))) begin
            n_chan = '1;
        end else begin
            n_chan = w_q[CHAN_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r6_chan <= n_chan;
        end
    end

    assign o_chan = r6_chan;

endmodule

FILE: sv/hsl_to_rgb_converter.sv
// Top level of the HSL to RGB converter: stream ports, stage valid chain, channels.
// Depends on hsl_pkg, hsl_front and hsl_chan.
`timescale 1ns / 1ps

// Converts one 8-bit HSL pixel (hue wheel of 256 steps) to one 8-bit RGB pixel
// in exact fixed point; zero saturation gives white. Six register stages: a
// pixel accepted into stage 1 moves on through stages 2 to 6 in order and
// leaves from stage 6, and one pixel can be taken every clock while the
// output is not stalled. The rate is set by the per-stage handshake:
// each stage loads whenever it is empty or the stage after it moves, so a
// stalled output stops only the stages that are full behind it. The longest
// path is the 16x9 multiplier of stage three.
module hsl_to_rgb_converter import hsl_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // hue [7:0], saturation [15:8], lightness [23:16]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata    // red [7:0], green [15:8], blue [23:16]
);

    logic [NUM_STAGES-1:0] r_vld;
    logic [NUM_STAGES-1:0] n_vld;
    logic [NUM_STAGES:0]   w_rdy;
    t_front                w_front;
    logic [CHAN_W-1:0]     w_red;
    logic [CHAN_W-1:0]     w_green;
    logic [CHAN_W-1:0]     w_blue;

    // A stage may load when empty or when the next one takes its transaction
    always_comb begin
        w_rdy[NUM_STAGES] = m_axis_tready;
        for (int k = NUM_STAGES - 1; k >= 0; k--) begin
            w_rdy[k] = !r_vld[k] || w_rdy[k+1];
        end
    end

    always_comb begin
        n_vld = r_vld;
        for (int k = 0; k < NUM_STAGES; k++) begin
            if (w_rdy[k]) begin
                n_vld[k] = (k == 0) ? s_axis_tvalid : r_vld[(k == 0) ? 0 : k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    // Stages 1..3
    hsl_front u_front (
        .i_clk   (i_clk),
        .i_en    (w_rdy[2:0]),
        .i_hue   (s_axis_tdata[7:0]),
        .i_sat   (s_axis_tdata[15:8]),
        .i_light (s_axis_tdata[23:16]),
        .o_front (w_front)
    );

    // Stages 4..6, one lane per colour
    hsl_chan u_red (
        .i_clk   (i_clk),
        .i_en    (w_rdy[5:3]),
        .i_part  (part_sel(w_front.sext, LANE_RED)),
        .i_front (w_front),
        .o_chan  (w_red)
    );

    hsl_chan u_green (
        .i_clk   (i_clk),
        .i_en    (w_rdy[5:3]),
        .i_part  (part_sel(w_front.sext, LANE_GREEN)),
        .i_front (w_front),
        .o_chan  (w_green)
    );

    hsl_chan u_blue (
        .i_clk   (i_clk),
        .i_en    (w_rdy[5:3]),
        .i_part  (part_sel(w_front.sext, LANE_BLUE)),
        .i_front (w_front),
        .o_chan  (w_blue)
    );

    assign s_axis_tready = w_rdy[0];
    assign m_axis_tvalid = r_vld[NUM_STAGES-1];
    assign m_axis_tdata  = {w_blue, w_green, w_red};

endmodule

FILE: sv/hsl_checker.sv
// Port-level checks for the HSL to RGB converter, bound to the top level.
// Depends on assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module hsl_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tready,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [23:0] m_axis_tdata
);

    logic w_out_stall;

    assign w_out_stall = m_axis_tvalid && !m_axis_tready;

    // Nothing comes out straight after reset
    `ASSERT_ALWAYS(a_rst_empty, !i_rst_n |=> !m_axis_tvalid, "output valid after reset")

    // A held result keeps its value
    `ASSERT_CLK(a_out_hold, w_out_stall |=> m_axis_tvalid && $stable(m_axis_tdata), "held data changed")

    // With the sink ready the whole pipeline moves
    `ASSERT_CLK(a_flow, m_axis_tready |-> s_axis_tready, "input stalled while output ready")

    // An empty output stage cannot hold back the input
    `ASSERT_CLK(a_empty_rdy, !m_axis_tvalid |-> s_axis_tready, "input stalled with output empty")

endmodule

bind hsl_to_rgb_converter hsl_checker u_hsl_checker (.*);
